@@ rtl/core/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// shared beat types and constants for the masked byte pattern scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

    // deepest pattern the window can hold
    localparam int unsigned WIN_DEPTH = 32;

    // byte position width and saturation point
    localparam int unsigned POS_W = 32;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CARE_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE      = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_offset;
    } out_beat_t;

endpackage

@@ rtl/core/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell
// one window byte with its masked compare against one pattern byte
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;

    // compare the byte this cell is about to take
    assign hit      = !care || (byte_in == pat_byte);
    assign byte_out = byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

@@ rtl/core/mbps_out_buf.sv @@
// ----------------------------------------------------------------------------
// mbps_out_buf
// output register with a skid stage for result beats
// ----------------------------------------------------------------------------
module mbps_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  mbps_pkg::out_beat_t res_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mbps_pkg::out_beat_t out_data,
    output logic               full
);

    import mbps_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_beat_t out_reg;
    out_beat_t skid_reg;
    logic      slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (slot_free)
        begin
            out_valid_next  = skid_valid_reg || res_valid;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // new results must arrive only while the skid stage is empty; unchecked here
    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_data;
        end
        else if (res_valid)
        begin
            skid_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign full      = skid_valid_reg;

endmodule

@@ rtl/core/masked_byte_pattern_scanner.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// a result beat leaves through the output register, or through the skid register while the output is stalled
// throughput: one byte per cycle while in_stall is low, set by the shift of the cell chain
// in_stall rises only while a second result waits behind a stalled output
// reset: control, fill count, position and pattern registers clear; window bytes do not
// slides a window of PATTERN_LEN bytes through a row of compare cells and reports
// the first masked match of each region, or not-found at the region's last byte
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
    parameter int unsigned PATTERN_LEN = 29
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mbps_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mbps_pkg::out_beat_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import mbps_pkg::*;

    localparam int unsigned FILL_W = $clog2(PATTERN_LEN + 1);

    // pattern and care registers
    logic [3:0][CFG_DATA_W-1:0] pat_reg;
    logic [CARE_W-1:0]          care_reg;

    // region state
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic              match_done_reg;
    logic              match_done_next;

    // handshake and per-beat control
    logic              in_fire;
    logic              shift_en;
    logic [FILL_W-1:0] fill_inc;
    logic              window_full;
    logic              match;
    logic              res_valid;
    out_beat_t         res_data;

    // cell chain: cell 0 holds the oldest byte, the top cell takes the new one
    logic [PATTERN_LEN-1:0][7:0] win_byte;
    logic [PATTERN_LEN-1:0]      cell_hit;

    assign in_fire  = in_valid && !in_stall;
    assign shift_en = in_fire && !match_done_reg;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_LEN; gi++)
        begin : g_cell
            logic [7:0] byte_in;

            if (gi == PATTERN_LEN - 1)
            begin : g_head
                assign byte_in = in_data.data_byte;
            end
            else
            begin : g_link
                assign byte_in = win_byte[gi + 1];
            end

            mbps_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .byte_in  (byte_in),
                .pat_byte (pat_reg[gi >> 3][(gi & 7) * 8 +: 8]),
                .care     (care_reg[gi]),
                .byte_out (win_byte[gi]),
                .hit      (cell_hit[gi])
            );
        end
    endgenerate

    // fill count saturates at the pattern length
    assign fill_inc    = (fill_reg < FILL_W'(PATTERN_LEN)) ? fill_reg + 1'b1 : fill_reg;
    assign window_full = (fill_inc == FILL_W'(PATTERN_LEN));
    assign match       = shift_en && window_full && (&cell_hit);

    // a result on the first match, or on the last byte of a region with no match
    assign res_valid = in_fire && (match || (in_data.last_byte && !match_done_reg));

    always_comb
    begin
        res_data.found        = match;
        res_data.match_offset = match ? position_reg - POS_W'(PATTERN_LEN - 1) : '0;
    end

    always_comb
    begin
        fill_next       = fill_reg;
        position_next   = position_reg;
        match_done_next = match_done_reg;
        if (in_fire)
        begin
            if (in_data.last_byte)
            begin
                // region ends: clear for the next one
                fill_next       = '0;
                position_next   = '0;
                match_done_next = 1'b0;
            end
            else if (shift_en)
            begin
                fill_next       = fill_inc;
                position_next   = (position_reg != POS_MAX) ? position_reg + 1'b1
                                                            : position_reg;
                match_done_next = match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            position_reg   <= '0;
            match_done_reg <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            position_reg   <= position_next;
            match_done_reg <= match_done_next;
        end
    end

    // configuration writes; indexes past the care mask are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            care_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAT_0_7:   pat_reg[0] <= cfg_data;
                CFG_PAT_8_15:  pat_reg[1] <= cfg_data;
                CFG_PAT_16_23: pat_reg[2] <= cfg_data;
                CFG_PAT_24_31: pat_reg[3] <= cfg_data;
                CFG_CARE:      care_reg   <= cfg_data[CARE_W-1:0];
                default:       ;
            endcase
        end
    end

    // result beats leave through an output register with a skid stage
    mbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .full      (in_stall)
    );

endmodule

@@ tb/masked_byte_pattern_scanner_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_checker
// watches the byte, result and register ports, predicts the scan verdict of
// every region and compares each result beat with the oldest prediction
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_checker #(
    parameter int unsigned PATTERN_LEN = 29
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  mbps_pkg::in_beat_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  mbps_pkg::out_beat_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  outstanding
);
    import mbps_pkg::*;

    localparam int unsigned SPAN = (PATTERN_LEN < 1) ? 1 :
                                   (PATTERN_LEN > WIN_DEPTH) ? WIN_DEPTH : PATTERN_LEN;

    logic [CFG_DATA_W-1:0] pat_words [4];
    logic [CARE_W-1:0]     care_bits;
    logic [7:0]            recent [WIN_DEPTH];
    int unsigned           held;
    logic [POS_W-1:0]      pos;
    logic                  hit_seen;
    out_beat_t             scan_verdicts [$];

    function automatic logic [7:0] pattern_at(input int unsigned i);
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // the last SPAN bytes against the pattern, wildcards skipped
    function automatic bit window_hits();
        for (int unsigned i = 0; i < SPAN; i++)
        begin
            if (care_bits[i] && recent[WIN_DEPTH - SPAN + i] != pattern_at(i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic scan_byte(input in_beat_t beat);
        out_beat_t verdict;
        if (!hit_seen)
        begin
            for (int k = 0; k < WIN_DEPTH - 1; k++)
                recent[k] = recent[k + 1];
            recent[WIN_DEPTH - 1] = beat.data_byte;
            if (held < SPAN)
                held++;
            if (held >= SPAN && window_hits())
            begin
                verdict.found        = 1'b1;
                verdict.match_offset = pos - POS_W'(SPAN - 1);
                scan_verdicts.push_back(verdict);
                hit_seen = 1'b1;
            end
            if (pos != POS_MAX)
                pos++;
        end
        if (beat.last_byte)
        begin
            if (!hit_seen)
            begin
                verdict.found        = 1'b0;
                verdict.match_offset = '0;
                scan_verdicts.push_back(verdict);
            end
            held     = 0;
            pos      = '0;
            hit_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
                pat_words[r] = '0;
            care_bits  = '0;
            held       = 0;
            pos        = '0;
            hit_seen   = 1'b0;
            mismatches = 0;
            scan_verdicts.delete();
            outstanding <= 0;
        end
        else
        begin
            // a result leaves through a register after its byte, so compare before predicting
            if (out_valid && !out_stall)
            begin
                if (scan_verdicts.size() == 0)
                begin
                    $error("result beat with nothing expected: found %0d offset %0d",
                           out_data.found, out_data.match_offset);
                    mismatches++;
                end
                else
                begin
                    want = scan_verdicts.pop_front();
                    if (out_data.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, out_data.found);
                        mismatches++;
                    end
                    if (out_data.match_offset !== want.match_offset)
                    begin
                        $error("match_offset: expected %0d, got %0d",
                               want.match_offset, out_data.match_offset);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAT_0_7:   pat_words[0] = cfg_data;
                    CFG_PAT_8_15:  pat_words[1] = cfg_data;
                    CFG_PAT_16_23: pat_words[2] = cfg_data;
                    CFG_PAT_24_31: pat_words[3] = cfg_data;
                    CFG_CARE:      care_bits    = cfg_data[CARE_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && !in_stall)
                scan_byte(in_data);
            outstanding <= scan_verdicts.size();
        end
    end

endmodule

@@ tb/masked_byte_pattern_scanner_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb
// drives byte regions into the scanner under several pattern and care mask
// settings, with random idle and stall on both channels, and reports the
// verdict of the checker that sits beside the block
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
    import mbps_pkg::*;

    localparam int unsigned PATTERN_LEN    = 29;
    localparam int          ITEM_TARGET    = 1250;
    localparam int          REGION_TARGET  = 30;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          IDLE_PCT       = 36;

    // prologue-like bytes, byte 0 in the low bits, cycled to fill a pattern
    localparam logic [95:0] SEED_BYTES = {8'h7D, 8'h8B, 8'hCC, 8'hEC, 8'h53, 8'hC6,
                                          8'h81, 8'hE8, 8'h56, 8'h57, 8'hE5, 8'h55};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_beat_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_beat_t              out_data;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     outstanding;

    // stimulus-side copy of the settings, used only to build embedded patterns
    logic [CFG_DATA_W-1:0]  pat_cfg [4];
    logic [CARE_W-1:0]      care_cfg;

    int                     items_sent   = 0;
    int                     regions_sent = 0;
    bit                     tx_quiet     = 1'b0;
    bit                     rx_quiet     = 1'b0;
    bit                     rx_hold      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    masked_byte_pattern_scanner #(
        .PATTERN_LEN (PATTERN_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    masked_byte_pattern_scanner_checker #(
        .PATTERN_LEN (PATTERN_LEN)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side: random stall, quiet stretches, and one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                // block fills up behind this, so in_stall has to rise
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // one byte beat; valid stays up and the payload holds while stalled
    task automatic send_beat(input logic [7:0] b, input logic lst);
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, lst};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // one region: pick below 55 embeds the pattern (sometimes broken),
    // below 80 is a short region, otherwise plain noise at least a window long
    task automatic send_region(input int pick);
        logic [7:0] bytes [$];
        int         lead;
        int         tail;
        int         len;
        int         j;
        if (pick < 55)
        begin
            lead = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12);
            repeat (lead) bytes.push_back(8'($urandom));
            for (int i = 0; i < PATTERN_LEN; i++)
                bytes.push_back(care_cfg[i] ? pat_cfg[i / 8][(i % 8) * 8 +: 8]
                                            : 8'($urandom));
            // broken window: flip one byte, which only matters on a care byte
            if ($urandom_range(3) == 0)
            begin
                j = lead + $urandom_range(PATTERN_LEN - 1);
                bytes[j] = bytes[j] ^ 8'($urandom_range(255, 1));
            end
            // bytes after a hit must be ignored
            tail = $urandom_range(6);
            repeat (tail) bytes.push_back(8'($urandom));
        end
        else
        begin
            if (pick < 80)
                len = $urandom_range(PATTERN_LEN - 1, 1);
            else
                len = $urandom_range(2 * PATTERN_LEN, PATTERN_LEN);
            repeat (len) bytes.push_back(8'($urandom));
        end
        for (int k = 0; k < bytes.size(); k++)
            send_beat(bytes[k], k == bytes.size() - 1);
        regions_sent++;
    endtask

    task automatic run_items(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
            send_region($urandom_range(99));
    endtask

    // stop offering and wait until every predicted result has come out;
    // the first edge lets the count catch up with the last accepted beat
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // registers only change with the block idle; an ignored byte can leave
    // work in flight after the last result, hence the extra cycles
    task automatic write_cfg(input logic [CFG_DATA_W-1:0] p0, input logic [CFG_DATA_W-1:0] p1,
                             input logic [CFG_DATA_W-1:0] p2, input logic [CFG_DATA_W-1:0] p3,
                             input logic [CARE_W-1:0] care, input bit junk);
        drain();
        repeat (4) @(posedge clk);
        pat_cfg[0] = p0;
        pat_cfg[1] = p1;
        pat_cfg[2] = p2;
        pat_cfg[3] = p3;
        care_cfg   = care;
        put_reg(CFG_PAT_0_7, p0);
        put_reg(CFG_PAT_8_15, p1);
        put_reg(CFG_PAT_16_23, p2);
        put_reg(CFG_PAT_24_31, p3);
        put_reg(CFG_CARE, CFG_DATA_W'(care));
        // indexes past the care mask have to be ignored
        if (junk)
        begin
            for (int r = int'(CFG_CARE) + 1; r < (1 << CFG_IDX_W); r++)
                put_reg(CFG_IDX_W'(r), {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] seeded [4];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_PAT_0_7;
        cfg_data  = '0;
        for (int r = 0; r < 4; r++)
            pat_cfg[r] = '0;
        care_cfg = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: every byte is a wildcard
        // one-byte region with all bits set, never fills the window
        send_beat(8'hFF, 1'b1);
        // short region ending on a byte with only the top bit set
        send_beat(8'h00, 1'b0);
        send_beat(8'h80, 1'b1);
        // exactly one window long: the hit lands on the last byte, offset zero
        for (int i = 0; i < PATTERN_LEN; i++)
            send_beat((i % 2) ? 8'hFF : 8'h00, i == PATTERN_LEN - 1);

        // prologue-style pattern, every byte cared, bits past the length set too
        for (int i = 0; i < 32; i++)
            seeded[i / 8][(i % 8) * 8 +: 8] = SEED_BYTES[(i % 12) * 8 +: 8];
        write_cfg(seeded[0], seeded[1], seeded[2], seeded[3], '1, 1'b0);
        run_items(220);

        // all-ones pattern, exact care over the length, no idling on either side
        write_cfg('1, '1, '1, '1, CARE_W'((64'd1 << PATTERN_LEN) - 1), 1'b0);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_items(200);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // random pattern, sparse care
        write_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, $urandom & $urandom & $urandom, 1'b0);
        run_items(100);
        // long hold-off on the result side while short regions keep coming
        rx_hold = 1'b1;
        repeat (10) send_region(60);
        // pause the byte side until the block has handed out everything
        drain();
        run_items(100);

        // only the first and last window bytes cared, plus ignored indexes
        write_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, CARE_W'((64'd1 << (PATTERN_LEN - 1)) | 64'd1), 1'b1);
        run_items(220);

        // all wildcards again with a random pattern behind them
        write_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, '0, 1'b1);
        run_items(120);

        // random dense care for the rest of the run
        write_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, $urandom | $urandom, 1'b0);
        while (items_sent < ITEM_TARGET || regions_sent < REGION_TARGET)
            send_region($urandom_range(99));

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("masked_byte_pattern_scanner: match");
        else
            $display("masked_byte_pattern_scanner: mismatch");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("masked_byte_pattern_scanner: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mbps_pkg.sv
rtl/core/mbps_cell.sv
rtl/core/mbps_out_buf.sv
rtl/core/masked_byte_pattern_scanner.sv
tb/masked_byte_pattern_scanner_checker.sv
tb/masked_byte_pattern_scanner_tb.sv
